/* rtl/core/anp_pkg.sv */
package anp_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       first_of_string;
		logic       last_of_string;
	} in_word_t;

	typedef struct packed {
		logic [63:0] parsed_value;
		logic [15:0] end_offset;
	} out_word_t;

	typedef logic [0:0] cfg_index_t;
	typedef logic [4:0] cfg_data_t;

	localparam cfg_index_t CFG_NUMBER_BASE = 1'b0;
	localparam cfg_index_t CFG_SIGNED_MODE = 1'b1;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_BEGIN  = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_XPEND  = 6'b001000,
		PH_HEX0   = 6'b010000,
		PH_DIGITS = 6'b100000
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [4:0] base;
		logic       negate;
		logic       given;
	} parse_ctl_t;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_LOWER_X = 8'h78;
	localparam logic [7:0] CASE_BIT     = 8'h20;

	localparam logic [4:0] BASE_OCT = 5'd8;
	localparam logic [4:0] BASE_DEC = 5'd10;
	localparam logic [4:0] BASE_HEX = 5'd16;

endpackage

/* rtl/core/anp_step.sv */
module anp_step #(
	parameter int COUNT_BITS = 16
) (
	input  anp_pkg::in_word_t   word,
	input  logic [4:0]          number_base,
	input  logic                signed_mode,
	input  anp_pkg::parse_ctl_t ctl,
	input  logic [63:0]         acc,
	input  logic [COUNT_BITS-1:0] cnt,
	output anp_pkg::parse_ctl_t ctl_next,
	output logic [63:0]         acc_next,
	output logic [COUNT_BITS-1:0] cnt_next,
	output logic                emit,
	output logic [15:0]         end_offset
);

	localparam int OW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	anp_pkg::parse_ctl_t w_ctl;
	logic [63:0]           w_acc;
	logic [COUNT_BITS-1:0] w_cnt;
	logic [COUNT_BITS-1:0] cnt_inc1;
	logic [COUNT_BITS-1:0] cnt_inc2;
	logic [7:0]            lc;
	logic                  is_dec;
	logic                  is_hex;
	logic                  is_x;
	logic [3:0]            dig_val;
	logic [4:0]            dig_base;
	logic                  dig_ok;
	logic [63:0]           mac;
	logic                  go;
	logic [OW-1:0]         cnt_wide;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
	endfunction

	always_comb begin
		w_ctl = ctl;
		w_acc = acc;
		w_cnt = cnt;
		if (word.first_of_string) begin
			w_ctl.phase  = anp_pkg::PH_BEGIN;
			w_ctl.base   = number_base;
			w_ctl.negate = 1'b0;
			w_ctl.given  = 1'b0;
			w_acc        = '0;
			w_cnt        = '0;
		end
	end

	// character decode
	assign lc      = word.char_code | anp_pkg::CASE_BIT;
	assign is_dec  = (word.char_code >= anp_pkg::CHAR_ZERO) &&
		(word.char_code <= anp_pkg::CHAR_NINE);
	assign is_hex  = is_dec || ((lc >= anp_pkg::CHAR_LOWER_A) && (lc <= anp_pkg::CHAR_LOWER_F));
	assign is_x    = (lc == anp_pkg::CHAR_LOWER_X);
	assign dig_val = is_dec ? word.char_code[3:0] : 4'(lc[3:0] + 4'd9);

	// base the digit would be taken in
	always_comb begin
		if (w_ctl.phase == anp_pkg::PH_BEGIN && w_ctl.base == 5'd0) begin
			dig_base = anp_pkg::BASE_DEC;
		end else if (w_ctl.phase == anp_pkg::PH_XPEND) begin
			dig_base = anp_pkg::BASE_HEX;
		end else begin
			dig_base = w_ctl.base;
		end
	end

	assign dig_ok   = is_hex && ({1'b0, dig_val} < dig_base);
	assign mac      = 64'(w_acc * dig_base) + 64'(dig_val);
	assign cnt_inc1 = sat_inc(w_cnt);
	assign cnt_inc2 = sat_inc(cnt_inc1);

	always_comb begin
		ctl_next = w_ctl;
		acc_next = w_acc;
		cnt_next = w_cnt;
		go       = 1'b1;
		emit     = 1'b0;
		if (!w_ctl.given) begin
			case (w_ctl.phase)
				anp_pkg::PH_BEGIN: begin
					if (signed_mode && w_cnt == '0 && word.char_code == anp_pkg::CHAR_MINUS) begin
						ctl_next.negate = 1'b1;
						cnt_next        = cnt_inc1;
					end else if (w_ctl.base == 5'd0 && word.char_code == anp_pkg::CHAR_ZERO) begin
						ctl_next.base  = anp_pkg::BASE_OCT;
						ctl_next.phase = anp_pkg::PH_ZERO;
						cnt_next       = cnt_inc1;
					end else if (w_ctl.base == anp_pkg::BASE_HEX &&
						word.char_code == anp_pkg::CHAR_ZERO) begin
						ctl_next.phase = anp_pkg::PH_HEX0;
						cnt_next       = cnt_inc1;
					end else begin
						if (w_ctl.base == 5'd0) begin
							ctl_next.base = anp_pkg::BASE_DEC;
						end
						go = dig_ok;
						if (dig_ok) begin
							acc_next       = mac;
							cnt_next       = cnt_inc1;
							ctl_next.phase = anp_pkg::PH_DIGITS;
						end
					end
				end
				anp_pkg::PH_ZERO: begin
					if (is_x) begin
						ctl_next.phase = anp_pkg::PH_XPEND;
					end else begin
						go = dig_ok;
						if (dig_ok) begin
							acc_next       = mac;
							cnt_next       = cnt_inc1;
							ctl_next.phase = anp_pkg::PH_DIGITS;
						end
					end
				end
				anp_pkg::PH_XPEND: begin
					go = is_hex;
					if (is_hex) begin
						ctl_next.base  = anp_pkg::BASE_HEX;
						acc_next       = mac;
						cnt_next       = cnt_inc2;
						ctl_next.phase = anp_pkg::PH_DIGITS;
					end
				end
				anp_pkg::PH_HEX0: begin
					if (is_x) begin
						ctl_next.phase = anp_pkg::PH_DIGITS;
						cnt_next       = cnt_inc1;
					end else begin
						go = dig_ok;
						if (dig_ok) begin
							acc_next       = mac;
							cnt_next       = cnt_inc1;
							ctl_next.phase = anp_pkg::PH_DIGITS;
						end
					end
				end
				default: begin
					go = dig_ok;
					if (dig_ok) begin
						acc_next       = mac;
						cnt_next       = cnt_inc1;
						ctl_next.phase = anp_pkg::PH_DIGITS;
					end
				end
			endcase
			if (!go || word.last_of_string) begin
				emit           = 1'b1;
				ctl_next.given = 1'b1;
				ctl_next.phase = anp_pkg::PH_IDLE;
			end
		end
	end

	assign cnt_wide   = OW'(cnt_next);
	assign end_offset = (cnt_wide > OW'(65535)) ? 16'hFFFF : cnt_wide[15:0];

endmodule

/* rtl/core/ascii_number_parser.sv */
// Streaming integer parser: takes one character word per cycle, a string opening with
// first_of_string, and gives one result word per string (value modulo 2^64 and end offset)
// at the character that ends the number or at last_of_string. A word is accepted every
// cycle unless the input stalls; a character passes the input register and then the
// result register before its result is offered. The rate is set by the combinational
// accumulate-multiply-add on the 64-bit accumulator; input stalls only while a
// finished result waits in the result register and the next character would also
// produce one. Write number_base and signed_mode only while the parser is idle.
module ascii_number_parser #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  anp_pkg::in_word_t     in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output anp_pkg::out_word_t    out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  anp_pkg::cfg_index_t   cfg_index,
	input  anp_pkg::cfg_data_t    cfg_data
);

	logic [4:0]            number_base_q;
	logic                  signed_mode_q;
	logic                  in_valid_s1;
	anp_pkg::in_word_t     in_word_s1;
	anp_pkg::parse_ctl_t   ctl_q;
	logic [63:0]           acc_q;
	logic [COUNT_BITS-1:0] cnt_q;
	anp_pkg::parse_ctl_t   ctl_next;
	logic [63:0]           acc_next;
	logic [COUNT_BITS-1:0] cnt_next;
	logic                  step_emit;
	logic [15:0]           step_offset;
	logic                  s1_go;
	logic                  out_valid_q;
	logic [63:0]           out_value_q;
	logic                  out_neg_q;
	logic [15:0]           out_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
			signed_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				anp_pkg::CFG_NUMBER_BASE: number_base_q <= cfg_data;
				anp_pkg::CFG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	anp_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.word        (in_word_s1),
		.number_base (number_base_q),
		.signed_mode (signed_mode_q),
		.ctl         (ctl_q),
		.acc         (acc_q),
		.cnt         (cnt_q),
		.ctl_next    (ctl_next),
		.acc_next    (acc_next),
		.cnt_next    (cnt_next),
		.emit        (step_emit),
		.end_offset  (step_offset)
	);

	assign s1_go    = in_valid_s1 && (!step_emit || !out_valid_q || out_ready);
	assign in_ready = !in_valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase  <= anp_pkg::PH_IDLE;
			ctl_q.base   <= '0;
			ctl_q.negate <= 1'b0;
			ctl_q.given  <= 1'b1;
			acc_q        <= '0;
			cnt_q        <= '0;
		end else if (s1_go) begin
			ctl_q <= ctl_next;
			acc_q <= acc_next;
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && step_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && step_emit) begin
			out_value_q  <= acc_next;
			out_neg_q    <= ctl_next.negate;
			out_offset_q <= step_offset;
		end
	end

	assign out_valid              = out_valid_q;
	assign out_data.parsed_value  = out_neg_q ? 64'(~out_value_q + 64'd1) : out_value_q;
	assign out_data.end_offset    = out_offset_q;

	// a delivered string leaves the parser idle
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.given == (ctl_q.phase == anp_pkg::PH_IDLE))
	else $error("result flag and parse phase disagree");

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && step_emit |=> out_valid_q && ctl_q.given)
	else $error("emitted result not held in result register");

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && !in_word_s1.first_of_string |=> cnt_q >= $past(cnt_q))
	else $error("character count went backwards within a string");

endmodule
